@@ hw/rtl/ipv4_dap_pkg.sv @@
// Shared types and constants for the IPv4 dotted address parser.
package ipv4_dap_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	// Character classes produced by the front end
	typedef enum logic [2:0] {
		CLS_DIGIT,
		CLS_HEXLET,
		CLS_XMARK,
		CLS_DOT,
		CLS_BLANK,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] val;
		logic       nul;
	} tok_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

@@ hw/rtl/ipv4_dotted_address_parser_core.sv @@
// Top level of the IPv4 dotted address parser: classifier, token queue, parse engine.
//
//  channel | signals                        | beat
//  --------+--------------------------------+-------------------------------------
//  in      | in_valid, in_ready, ch         | one character; 0 ends the string
//  out     | out_valid, out_ready,          | one result per string, sent after
//          | valid_res, address             | its terminating character
//
// Each character is one accumulate step (shift-add by 8, 10 or 16) in the parse engine;
// throughput is one character per cycle unless the queue is empty or a terminator waits.
// out_valid is registered: a terminator accepted into an empty queue is written to the
// queue, then popped into the result register that drives out_valid.
// Reset clears the queue, the parse state and the result register.
// A stalled output holds back only a terminator at the queue head; characters behind it
// wait in the queue, and in_ready drops only when the queue of QueueDepth entries is full.
module ipv4_dotted_address_parser_core #(
	parameter int unsigned QueueDepth = ipv4_dap_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        valid_res,
	output logic [31:0] address
);
	import ipv4_dap_pkg::*;

	tok_t    wr_tok;
	tok_t    rd_tok;
	q_stat_t q_stat;
	logic    push;
	logic    pop;

	ipv4_dap_classify u_classify (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.ch       (ch),
		.q_stat   (q_stat),
		.push     (push),
		.tok      (wr_tok)
	);

	ipv4_dap_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_tok (wr_tok),
		.pop    (pop),
		.rd_tok (rd_tok),
		.q_stat (q_stat)
	);

	ipv4_dap_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (rd_tok),
		.q_stat    (q_stat),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.valid_res (valid_res),
		.address   (address)
	);

	// A failed string always reports address zero
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> address == 32'd0)
		else $error("invalid result carries a nonzero address");

	// A terminator into an idle block yields a result via the queue and the result register
	a_nul_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && ch == 8'd0 && q_stat.empty && !out_valid
		|-> ##2 out_valid)
		else $error("result missing after terminator");

	// Queue status flags are never both set
	a_q_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty together");

endmodule

@@ hw/rtl/ipv4_dap_classify.sv @@
// Front end: accepts characters and tags each one with its class and digit value.
module ipv4_dap_classify (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            ch,
	input  ipv4_dap_pkg::q_stat_t q_stat,
	output logic                  push,
	output ipv4_dap_pkg::tok_t    tok
);
	import ipv4_dap_pkg::*;

	assign in_ready = !q_stat.full;
	assign push     = in_valid && !q_stat.full;

	always_comb begin
		tok.nul = (ch == 8'd0);
		tok.val = ch[3:0];
		if (ch >= 8'h30 && ch <= 8'h39) begin
			tok.cls = CLS_DIGIT;
		end else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46)) begin
			// a..f and A..F both map to low nibble plus nine
			tok.cls = CLS_HEXLET;
			tok.val = ch[3:0] + 4'd9;
		end else if (ch == 8'h78 || ch == 8'h58) begin
			tok.cls = CLS_XMARK;
		end else if (ch == 8'h2e) begin
			tok.cls = CLS_DOT;
		end else if (ch == 8'h00 || ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d)) begin
			tok.cls = CLS_BLANK;
		end else begin
			tok.cls = CLS_OTHER;
		end
	end

endmodule

@@ hw/rtl/ipv4_dap_queue.sv @@
// Short token queue between the classifier and the parse engine.
module ipv4_dap_queue #(
	parameter int unsigned DEPTH = ipv4_dap_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ipv4_dap_pkg::tok_t    wr_tok,
	input  logic                  pop,
	output ipv4_dap_pkg::tok_t    rd_tok,
	output ipv4_dap_pkg::q_stat_t q_stat
);
	import ipv4_dap_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	tok_t          mem_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign rd_tok       = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == FULL_CNT);
	assign q_stat.empty = (cnt_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + IW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + IW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ hw/rtl/ipv4_dap_exec.sv @@
// Back end: runs the parse state machine on tokens and registers the result.
module ipv4_dap_exec (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ipv4_dap_pkg::tok_t    tok,
	input  ipv4_dap_pkg::q_stat_t q_stat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  valid_res,
	output logic [31:0]           address
);
	import ipv4_dap_pkg::*;

	typedef enum logic [1:0] {PH_START, PH_ZERO, PH_NUM, PH_DONE} phase_t;
	typedef enum logic [1:0] {RADIX_DEC, RADIX_OCT, RADIX_HEX} radix_t;

	phase_t      phase_q, nx_phase;
	radix_t      radix_q, nx_radix, eff_radix;
	logic [31:0] accum_q, nx_accum, macc, merged;
	logic [7:0]  part0_q, nx_part0;
	logic [15:0] part1_q, nx_part1;
	logic [23:0] part2_q, nx_part2;
	logic [1:0]  pcnt_q, nx_pcnt;
	logic        verdict_q, nx_verdict;
	logic        do_num, range_ok, res_ok;
	logic        res_valid_q;
	logic        res_flag_q;
	logic [31:0] res_addr_q;

	assign eff_radix = (phase_q == PH_ZERO) ? RADIX_OCT : radix_q;
	assign merged    = accum_q | {part0_q, 24'd0} | {part1_q, 16'd0} | {part2_q, 8'd0};

	always_comb begin
		case (eff_radix)
			RADIX_HEX: macc = {accum_q[27:0], 4'd0} + {28'd0, tok.val};
			RADIX_OCT: macc = {accum_q[28:0], 3'd0} + {28'd0, tok.val};
			default:   macc = {accum_q[28:0], 3'd0} + {accum_q[30:0], 1'b0}
				+ {28'd0, tok.val};
		endcase
		case (pcnt_q)
			2'd0:    range_ok = 1'b1;
			2'd1:    range_ok = (accum_q[31:24] == '0);
			2'd2:    range_ok = (accum_q[31:16] == '0);
			default: range_ok = (accum_q[31:8] == '0);
		endcase
	end

	always_comb begin
		nx_phase   = phase_q;
		nx_radix   = radix_q;
		nx_accum   = accum_q;
		nx_part0   = part0_q;
		nx_part1   = part1_q;
		nx_part2   = part2_q;
		nx_pcnt    = pcnt_q;
		nx_verdict = verdict_q;
		do_num     = 1'b0;
		case (phase_q)
			PH_START: begin
				if (tok.cls != CLS_DIGIT) begin
					nx_verdict = 1'b0;
					nx_accum   = '0;
					nx_phase   = PH_DONE;
				end else if (tok.val == 4'd0) begin
					nx_accum = '0;
					nx_radix = RADIX_OCT;
					nx_phase = PH_ZERO;
				end else begin
					nx_accum = {28'd0, tok.val};
					nx_radix = RADIX_DEC;
					nx_phase = PH_NUM;
				end
			end
			PH_ZERO: begin
				nx_phase = PH_NUM;
				if (tok.cls == CLS_XMARK) begin
					nx_radix = RADIX_HEX;
				end else begin
					nx_radix = RADIX_OCT;
					do_num   = 1'b1;
				end
			end
			PH_NUM: do_num = 1'b1;
			default: ;
		endcase

		if (do_num) begin
			if (tok.cls == CLS_DIGIT || (tok.cls == CLS_HEXLET && eff_radix == RADIX_HEX)) begin
				nx_accum = macc;
			end else if (tok.cls == CLS_DOT && pcnt_q != 2'd3) begin
				// close this part and start the next
				case (pcnt_q)
					2'd0:    nx_part0 = accum_q[7:0];
					2'd1:    nx_part1 = accum_q[15:0];
					default: nx_part2 = accum_q[23:0];
				endcase
				nx_pcnt  = pcnt_q + 2'd1;
				nx_accum = '0;
				nx_phase = PH_START;
			end else if (tok.cls == CLS_BLANK && range_ok) begin
				nx_verdict = 1'b1;
				nx_accum   = merged;
				nx_phase   = PH_DONE;
			end else begin
				nx_verdict = 1'b0;
				nx_accum   = '0;
				nx_phase   = PH_DONE;
			end
		end
	end

	assign res_ok = (nx_phase == PH_DONE) && nx_verdict;

	// Hold a terminating beat until the result register is free
	assign pop = !q_stat.empty && (!tok.nul || !res_valid_q || out_ready);

	assign out_valid = res_valid_q;
	assign valid_res = res_flag_q;
	assign address   = res_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			radix_q     <= RADIX_DEC;
			accum_q     <= '0;
			part0_q     <= '0;
			part1_q     <= '0;
			part2_q     <= '0;
			pcnt_q      <= '0;
			verdict_q   <= 1'b0;
			res_valid_q <= 1'b0;
			res_flag_q  <= 1'b0;
			res_addr_q  <= '0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			if (pop) begin
				if (tok.nul) begin
					res_valid_q <= 1'b1;
					res_flag_q  <= res_ok;
					res_addr_q  <= res_ok ? nx_accum : '0;
					phase_q     <= PH_START;
					radix_q     <= RADIX_DEC;
					accum_q     <= '0;
					part0_q     <= '0;
					part1_q     <= '0;
					part2_q     <= '0;
					pcnt_q      <= '0;
					verdict_q   <= 1'b0;
				end else begin
					phase_q   <= nx_phase;
					radix_q   <= nx_radix;
					accum_q   <= nx_accum;
					part0_q   <= nx_part0;
					part1_q   <= nx_part1;
					part2_q   <= nx_part2;
					pcnt_q    <= nx_pcnt;
					verdict_q <= nx_verdict;
				end
			end
		end
	end

endmodule
